// ----- src/bcrw_pkg.sv -----
// Shared types and constants for the bit cursor read/write buffer.
// Holds the request codes, controller states and the item structs.
// No dependencies.
package bcrw_pkg;

  localparam int CFG_W  = 9;
  localparam int CNT_W  = 12;
  localparam int DATA_W = 8;

  localparam logic [CFG_W-1:0] LEN_RESET = 9'd256;

  typedef enum logic [2:0] {
    REQ_READ      = 3'd0,
    REQ_PEEK      = 3'd1,
    REQ_WRITE     = 3'd2,
    REQ_SEEK_FWD  = 3'd3,
    REQ_SEEK_BACK = 3'd4,
    REQ_REWIND    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_W1
  } state_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [CNT_W-1:0]  bit_count;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  bits_done;
    logic              more_left;
  } out_item_t;

endpackage

// ----- src/bit_cursor_read_write_buffer_core.sv -----
// Top level of the bit cursor read/write buffer: byte store, cursor and controller.
// Depends on bcrw_pkg for request codes, states and item structs.
//
// Channel | Ports                          | Handshake
// --------+--------------------------------+-------------------------------------
// input   | start, busy, in_item           | beat taken when start && !busy
// result  | out_valid, out_item            | one-cycle strobe, cannot be stalled
// config  | cfg_valid, cfg_ready, cfg_data | write when cfg_valid && cfg_ready
//
// Seek, rewind and refused accesses: result the cycle after the beat, next beat at once.
// An access inside one byte steps through ST_B0, a read over two bytes ST_B0 and ST_B1,
// a write over two bytes ST_B0, ST_B1 and ST_W1; the store's single port sets the steps.
// Reset clears the cursor and sets the length to 256; the store itself is not cleared.
// Result beats cannot be stalled; busy holds off the next input beat.
module bit_cursor_read_write_buffer_core #(
  parameter int STORE_BYTES = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bcrw_pkg::in_item_t           in_item,
  output logic                         out_valid,
  output bcrw_pkg::out_item_t          out_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bcrw_pkg::CFG_W-1:0]   cfg_data
);

  localparam int ADDR_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int MAX_LEN = (STORE_BYTES < 511) ? STORE_BYTES : 511;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CUR_W   = LEN_W + 3;
  localparam int SK_W    = ((CUR_W > bcrw_pkg::CNT_W) ? CUR_W : bcrw_pkg::CNT_W) + 1;

  bcrw_pkg::state_t          state_r, state_nxt;
  logic [CUR_W-1:0]          cur_r, cur_nxt;
  logic [bcrw_pkg::CFG_W-1:0] len_r;
  logic [LEN_W-1:0]          eff_len;

  logic [2:0]                req_r, req_nxt;
  logic [2:0]                off_r, off_nxt;
  logic [3:0]                total_r, total_nxt;
  logic                      two_r, two_nxt;
  logic [ADDR_W-1:0]         addr_r, addr_nxt;
  logic [7:0]                wdata_r, wdata_nxt;
  logic [7:0]                data0_r, data0_nxt;

  logic                      out_valid_r, out_valid_nxt;
  bcrw_pkg::out_item_t       out_item_r, out_item_nxt;

  logic [7:0]                store_mem [STORE_BYTES];
  logic [7:0]                rd_data_r;
  logic [ADDR_W-1:0]         mem_addr;
  logic                      mem_we;
  logic [7:0]                mem_wd;

  // Decode of the incoming beat against the current cursor.
  logic [LEN_W-1:0]          byte_idx;
  logic [2:0]                off;
  logic [bcrw_pkg::CNT_W-1:0] cnt;
  logic [3:0]                n, first, total;
  logic                      is_rd, is_wr, two, xfer_ok;
  logic [CUR_W-1:0]          len_bits;
  logic [SK_W-1:0]           fwd_sum, back_dif;
  logic                      fwd_ok, back_ok;

  // Window over the one or two bytes of an access in flight.
  logic [15:0]               win, mask16, merged;
  logic [7:0]                rd_bits;

  assign busy      = (state_r != bcrw_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (32'(len_r) > STORE_BYTES) eff_len = LEN_W'(STORE_BYTES);
    else eff_len = LEN_W'(len_r);
  end

  always_comb begin
    byte_idx = cur_r[CUR_W-1:3];
    off      = cur_r[2:0];
    cnt      = in_item.bit_count;
    is_rd    = (in_item.req_type == bcrw_pkg::REQ_READ) ||
               (in_item.req_type == bcrw_pkg::REQ_PEEK);
    is_wr    = (in_item.req_type == bcrw_pkg::REQ_WRITE);
    if (cnt > bcrw_pkg::CNT_W'(8)) n = 4'd8;
    else n = cnt[3:0];
    first    = 4'd8 - {1'b0, off};
    two      = (({1'b0, byte_idx} + (LEN_W+1)'(1)) < {1'b0, eff_len}) && (n > first);
    if (two) total = n;
    else if (n < first) total = n;
    else total = first;
    xfer_ok  = (is_wr || (is_rd && (cnt <= bcrw_pkg::CNT_W'(8)))) &&
               (n != 4'd0) && (byte_idx < eff_len);
    len_bits = {eff_len, 3'b000};
    fwd_sum  = SK_W'(cur_r) + SK_W'(cnt);
    fwd_ok   = fwd_sum <= SK_W'(len_bits);
    back_dif = SK_W'(cur_r) - SK_W'(cnt);
    back_ok  = (SK_W'(cnt) <= SK_W'(cur_r)) && (back_dif <= SK_W'(len_bits));
  end

  always_comb begin
    if (state_r == bcrw_pkg::ST_B1) win = {rd_data_r, data0_r};
    else win = {8'h00, rd_data_r};
    mask16  = 16'((16'd1 << total_r) - 16'd1) << off_r;
    merged  = (win & ~mask16) | ((16'(wdata_r) << off_r) & mask16);
    rd_bits = 8'((win & mask16) >> off_r);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    total_nxt     = total_r;
    two_nxt       = two_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    data0_nxt     = data0_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    mem_addr      = addr_r;
    mem_we        = 1'b0;
    mem_wd        = merged[7:0];

    case (state_r)
      bcrw_pkg::ST_IDLE: begin
        // The first byte is fetched on the accepting edge itself.
        mem_addr = ADDR_W'(byte_idx);
        if (start) begin
          case (in_item.req_type)
            bcrw_pkg::REQ_READ, bcrw_pkg::REQ_PEEK, bcrw_pkg::REQ_WRITE: begin
              if (xfer_ok) begin
                req_nxt   = in_item.req_type;
                off_nxt   = off;
                total_nxt = total;
                two_nxt   = two;
                addr_nxt  = ADDR_W'(byte_idx);
                wdata_nxt = in_item.write_data;
                state_nxt = bcrw_pkg::ST_B0;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            bcrw_pkg::REQ_SEEK_FWD: begin
              out_valid_nxt = 1'b1;
              if (fwd_ok) begin
                cur_nxt                = CUR_W'(fwd_sum);
                out_item_nxt.bits_done = cnt;
              end
            end
            bcrw_pkg::REQ_SEEK_BACK: begin
              out_valid_nxt = 1'b1;
              if (back_ok) begin
                cur_nxt                = CUR_W'(back_dif);
                out_item_nxt.bits_done = cnt;
              end
            end
            bcrw_pkg::REQ_REWIND: begin
              out_valid_nxt = 1'b1;
              cur_nxt       = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      bcrw_pkg::ST_B0: begin
        if (two_r) begin
          data0_nxt = rd_data_r;
          mem_addr  = addr_r + ADDR_W'(1);
          state_nxt = bcrw_pkg::ST_B1;
        end else begin
          if (req_r == bcrw_pkg::REQ_WRITE) begin
            mem_we = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = bcrw_pkg::ST_IDLE;
        end
      end
      bcrw_pkg::ST_B1: begin
        if (req_r == bcrw_pkg::REQ_WRITE) begin
          mem_we    = 1'b1;
          data0_nxt = merged[15:8];
          state_nxt = bcrw_pkg::ST_W1;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = bcrw_pkg::ST_IDLE;
        end
      end
      bcrw_pkg::ST_W1: begin
        mem_we        = 1'b1;
        mem_addr      = addr_r + ADDR_W'(1);
        mem_wd        = data0_r;
        out_valid_nxt = 1'b1;
        state_nxt     = bcrw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bcrw_pkg::ST_IDLE;
      end
    endcase

    // A finishing access reports its bit count and moves the cursor, except for a peek.
    if (out_valid_nxt && (state_r != bcrw_pkg::ST_IDLE)) begin
      out_item_nxt.bits_done = bcrw_pkg::CNT_W'(total_r);
      if (req_r != bcrw_pkg::REQ_WRITE) out_item_nxt.read_data = rd_bits;
      if (req_r != bcrw_pkg::REQ_PEEK) cur_nxt = cur_r + CUR_W'(total_r);
    end
    out_item_nxt.more_left = (cur_nxt[CUR_W-1:3] < eff_len);
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_addr] <= mem_wd;
    rd_data_r <= store_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcrw_pkg::ST_IDLE;
      cur_r       <= '0;
      len_r       <= bcrw_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) len_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    off_r      <= off_nxt;
    total_r    <= total_nxt;
    two_r      <= two_nxt;
    addr_r     <= addr_nxt;
    wdata_r    <= wdata_nxt;
    data0_r    <= data0_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- src/bcrw_checker.sv -----
// Port-level checks for the bit cursor read/write buffer, bound to the top level.
// Depends on bcrw_pkg for the result struct.
module bcrw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bcrw_pkg::out_item_t out_item
);

  // Every accepted beat either reports at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted beat neither reported nor in progress");

  // The result beat coincides with the block becoming free.
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  // A result always follows an accepted beat or pending work.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result beat without a request");

  // Nonzero read data comes only from an access of one to eight bits.
  a_read_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.read_data != 8'd0)) |->
      ((out_item.bits_done != 12'd0) && (out_item.bits_done <= 12'd8)))
    else $error("read data with an impossible bit count");

endmodule

bind bit_cursor_read_write_buffer_core bcrw_checker u_bcrw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- verif/tb_top.sv -----
// Testbench for bit_cursor_read_write_buffer_core: directed and random bit accesses,
// seeks and stream length changes, all checked against a behavioral shadow of the store.
// Depends on bcrw_pkg (src/bcrw_pkg.sv) and the core RTL.
module tb_top;

  localparam int STORE_BYTES = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  // Request codes the block does not decode; each still gets a result beat with no bits done.
  localparam logic [2:0] REQ_RSVD_A = 3'd6;
  localparam logic [2:0] REQ_RSVD_B = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  bcrw_pkg::in_item_t         in_item = '0;
  logic                       out_valid;
  bcrw_pkg::out_item_t        out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [bcrw_pkg::CFG_W-1:0] cfg_data = '0;

  bit_cursor_read_write_buffer_core #(
    .STORE_BYTES(STORE_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block state, updated as each input beat is taken.
  logic [7:0]                 shadow_bytes [STORE_BYTES];
  int unsigned                shadow_cursor = 0;
  logic [bcrw_pkg::CFG_W-1:0] shadow_len = bcrw_pkg::LEN_RESET;

  bcrw_pkg::out_item_t pending_results [$];
  int        sender_idle_pct = 0;
  int        fail_count = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        len_writes = 0;
  int        cycle_count = 0;

  function automatic int unsigned eff_len();
    return (shadow_len > STORE_BYTES) ? STORE_BYTES : int'(shadow_len);
  endfunction

  // Moves 1 to 8 bits at the cursor and advances it; returns the bits moved.
  function automatic int unsigned move_bits(input int unsigned n, input logic [7:0] wdata,
                                            input bit do_write, output logic [7:0] rdata);
    int unsigned len, byte_i, off, first, total, win, mask;
    bit two;
    rdata = '0;
    len = eff_len();
    byte_i = shadow_cursor >> 3;
    off = shadow_cursor & 7;
    if (n == 0 || byte_i >= len) return 0;
    first = 8 - off;
    two = (byte_i + 1 < len) && (n > first);
    total = two ? n : ((n < first) ? n : first);
    win = 32'(shadow_bytes[byte_i]);
    if (two) win = win | (32'(shadow_bytes[byte_i + 1]) << 8);
    mask = ((32'd1 << total) - 1) << off;
    if (do_write) begin
      win = (win & ~mask) | ((32'(wdata) << off) & mask);
      shadow_bytes[byte_i] = win[7:0];
      if (two) shadow_bytes[byte_i + 1] = win[15:8];
    end else begin
      rdata = 8'((win & mask) >> off);
    end
    shadow_cursor += total;
    return total;
  endfunction

  function automatic bcrw_pkg::out_item_t predict_access(input logic [2:0] req,
                                                         input logic [11:0] cnt_in,
                                                         input logic [7:0] wdata);
    bcrw_pkg::out_item_t res;
    logic [7:0]  rd;
    int unsigned cnt, done, len, saved;
    rd = '0;
    done = 0;
    cnt = cnt_in;
    len = eff_len();
    case (req)
      bcrw_pkg::REQ_READ: begin
        if (cnt <= 8) done = move_bits(cnt, wdata, 1'b0, rd);
      end
      bcrw_pkg::REQ_PEEK: begin
        if (cnt <= 8) begin
          saved = shadow_cursor;
          done = move_bits(cnt, wdata, 1'b0, rd);
          shadow_cursor = saved;
        end
      end
      bcrw_pkg::REQ_WRITE: begin
        done = move_bits((cnt > 8) ? 8 : cnt, wdata, 1'b1, rd);
        rd = '0;
      end
      bcrw_pkg::REQ_SEEK_FWD: begin
        if (shadow_cursor + cnt <= 8 * len) begin
          shadow_cursor += cnt;
          done = cnt;
        end
      end
      bcrw_pkg::REQ_SEEK_BACK: begin
        if (cnt <= shadow_cursor && shadow_cursor - cnt <= 8 * len) begin
          shadow_cursor -= cnt;
          done = cnt;
        end
      end
      bcrw_pkg::REQ_REWIND: begin
        shadow_cursor = 0;
      end
      default: begin
      end
    endcase
    res.read_data = rd;
    res.bits_done = 12'(done);
    res.more_left = ((shadow_cursor >> 3) < len);
    return res;
  endfunction

  // Sends one beat; start stays high afterwards so back-to-back beats need no gap.
  task automatic send_item(input logic [2:0] req, input logic [11:0] cnt,
                           input logic [7:0] wdata);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_item <= '{req_type: req, bit_count: cnt, write_data: wdata};
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_access(req, cnt, wdata));
    items_sent++;
  endtask

  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_stream_len(input logic [bcrw_pkg::CFG_W-1:0] value);
    wait_results();
    while (busy !== 1'b0) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    shadow_len = value;
    len_writes++;
  endtask

  // Mostly well-formed accesses and seeks that stay near the valid range.
  task automatic send_random_access();
    int unsigned pick, span, lim;
    logic [2:0]  req;
    logic [11:0] cnt;
    lim = 8 * eff_len();
    pick = $urandom_range(99);
    if (pick < 30) req = bcrw_pkg::REQ_READ;
    else if (pick < 42) req = bcrw_pkg::REQ_PEEK;
    else if (pick < 72) req = bcrw_pkg::REQ_WRITE;
    else if (pick < 82) req = bcrw_pkg::REQ_SEEK_FWD;
    else if (pick < 92) req = bcrw_pkg::REQ_SEEK_BACK;
    else if (pick < 97) req = bcrw_pkg::REQ_REWIND;
    else req = ($urandom_range(1) != 0) ? REQ_RSVD_A : REQ_RSVD_B;
    pick = $urandom_range(19);
    case (req)
      bcrw_pkg::REQ_READ, bcrw_pkg::REQ_PEEK, bcrw_pkg::REQ_WRITE: begin
        if (pick < 16) cnt = 12'($urandom_range(1, 8));
        else if (pick == 16) cnt = '0;
        else cnt = 12'($urandom_range(9, 4095));
      end
      bcrw_pkg::REQ_SEEK_FWD: begin
        span = (shadow_cursor < lim) ? lim - shadow_cursor : 0;
        cnt = (pick < 3) ? 12'($urandom_range(4095)) : 12'($urandom_range(span + 4));
      end
      bcrw_pkg::REQ_SEEK_BACK: begin
        cnt = (pick < 3) ? 12'($urandom_range(4095)) : 12'($urandom_range(shadow_cursor + 4));
      end
      default: begin
        cnt = 12'($urandom_range(4095));
      end
    endcase
    send_item(req, cnt, 8'($urandom_range(255)));
  endtask

  task automatic check_field(input string field, input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Result beats cannot be stalled, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    bcrw_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, out_item);
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", 12'(want.read_data), 12'(out_item.read_data));
        check_field("bits_done", want.bits_done, out_item.bits_done);
        check_field("more_left", 12'(want.more_left), 12'(out_item.more_left));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every byte is written once up front so no later access reads an unwritten entry.
  task automatic test_fill_store();
    sender_idle_pct = 0;
    for (int i = 0; i < STORE_BYTES; i++) begin
      send_item(bcrw_pkg::REQ_WRITE, 12'd8, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_basic_access();
    // The cursor sits at the end after the fill.
    send_item(bcrw_pkg::REQ_WRITE, 12'd8, 8'hFF);
    send_item(bcrw_pkg::REQ_READ, 12'd1, 8'h00);
    send_item(bcrw_pkg::REQ_PEEK, 12'd8, 8'h00);
    send_item(bcrw_pkg::REQ_REWIND, 12'hFFF, 8'h00);
    send_item(bcrw_pkg::REQ_READ, 12'd0, 8'h00);
    send_item(bcrw_pkg::REQ_WRITE, 12'd0, 8'hFF);
    send_item(bcrw_pkg::REQ_READ, 12'd9, 8'h00);
    send_item(bcrw_pkg::REQ_PEEK, 12'hFFF, 8'h00);
    send_item(bcrw_pkg::REQ_READ, 12'd3, 8'h00);
    send_item(bcrw_pkg::REQ_PEEK, 12'd8, 8'h00);
    send_item(bcrw_pkg::REQ_READ, 12'd8, 8'h00);
    send_item(bcrw_pkg::REQ_WRITE, 12'hFFF, 8'hA5);
    send_item(bcrw_pkg::REQ_SEEK_BACK, 12'd8, 8'h00);
    send_item(bcrw_pkg::REQ_READ, 12'd8, 8'h00);
  endtask

  task automatic test_seek_bounds();
    send_item(bcrw_pkg::REQ_SEEK_FWD, 12'hFFF, 8'h00);
    send_item(bcrw_pkg::REQ_SEEK_BACK, 12'hFFF, 8'h00);
    // Park three bits short of the end so accesses get cut off there.
    send_item(bcrw_pkg::REQ_SEEK_FWD, 12'(8 * STORE_BYTES - 3 - shadow_cursor), 8'h00);
    send_item(bcrw_pkg::REQ_READ, 12'd8, 8'h00);
    send_item(bcrw_pkg::REQ_SEEK_BACK, 12'd3, 8'h00);
    send_item(bcrw_pkg::REQ_WRITE, 12'd8, 8'h00);
    send_item(bcrw_pkg::REQ_SEEK_FWD, 12'd0, 8'h00);
    send_item(bcrw_pkg::REQ_SEEK_BACK, 12'(8 * STORE_BYTES), 8'h00);
  endtask

  task automatic test_unused_codes();
    send_item(REQ_RSVD_A, 12'hFFF, 8'hFF);
    send_item(REQ_RSVD_B, 12'd0, 8'h00);
  endtask

  task automatic run_length_phase(input logic [bcrw_pkg::CFG_W-1:0] len_val,
                                  input int idle_pct, input int n);
    write_stream_len(len_val);
    sender_idle_pct = idle_pct;
    repeat (n) send_random_access();
    wait_results();
  endtask

  task automatic test_lengths();
    run_length_phase(bcrw_pkg::LEN_RESET, 0, 70);
    run_length_phase(9'd1, 77, 40);
    run_length_phase(9'd0, 30, 30);
    run_length_phase(9'd511, 0, 70);
    run_length_phase(9'd2, 77, 40);
    run_length_phase(9'($urandom_range(3, 255)), 30, 70);
    run_length_phase(bcrw_pkg::LEN_RESET, 77, 60);
    run_length_phase(9'($urandom_range(3, 255)), 30, 40);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_store();
    test_basic_access();
    test_seek_bounds();
    test_unused_codes();
    wait_results();
    test_lengths();
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d beats and checked %0d results across %0d stream length settings,",
             items_sent, results_checked, len_writes);
    $display("covering store fill, straddled accesses, end bounds, seeks and unused codes.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
